### design/rspd_pkg.sv
// shared types, codes and helpers for the packet deframer
`timescale 1ns / 1ps
`default_nettype none

package rspd_pkg;

   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int DATA_LENGTH_BITS    = 16;
   localparam int QS_LEN              = 10;

   localparam logic [7:0] CHAR_START    = 8'h24;  // '$'
   localparam logic [7:0] CHAR_END      = 8'h23;  // '#'
   localparam logic [7:0] CHAR_READ     = 8'h67;  // 'g'
   localparam logic [7:0] CHAR_WRITE    = 8'h47;  // 'G'

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_DATA = 2'd1,
      PHASE_HIGH = 2'd2,
      PHASE_LOW  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_MISMATCH = 2'd1,
      STATUS_NON_HEX  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CMD_EMPTY     = 3'd0,
      CMD_READ_REGS = 3'd1,
      CMD_WRITE_REGS = 3'd2,
      CMD_QUERY_SUP = 3'd3,
      CMD_UNKNOWN   = 3'd4
   } command_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   // bit 0 "g", bit 1 "G", bit 2 "qSupported"
   localparam logic [2:0] MATCH_ALL = 3'b111;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type r;
      r.ok    = 1'b1;
      r.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.value = 4'(c - 8'h37);
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [7:0] qs_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0: c = 8'h71;  // q
         4'd1: c = 8'h53;  // S
         4'd2: c = 8'h75;  // u
         4'd3: c = 8'h70;  // p
         4'd4: c = 8'h70;  // p
         4'd5: c = 8'h6f;  // o
         4'd6: c = 8'h72;  // r
         4'd7: c = 8'h74;  // t
         4'd8: c = 8'h65;  // e
         4'd9: c = 8'h64;  // d
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

### design/rsp_packet_deframer.sv
// remote serial protocol packet deframer, top level
// Bytes enter on the req_ channel, one per transfer; the block hunts for '$',
// then counts and sums data bytes until '#', then reads two hex checksum
// digits. On the transfer of the second digit it loads one result into the
// rsp_ output register: checksum status, command code, data length
// (saturating) and the modulo 256 sum. All other bytes give no result.
// rsp_valid rises in the cycle after the last checksum byte. One byte is
// taken every cycle while req_ready is high; per-byte state is updated in
// a single pass of logic. req_ready drops only while a result sits in the
// output register, rsp_ready is low and the next byte is a second checksum
// digit; other bytes keep flowing while the receiver stalls.
// csr_write_enable/csr_write_data set check_enable (1 after reset); when 0
// every packet reports ok status. Synchronous reset returns the block to
// hunting for '$' with an empty output register.
`timescale 1ns / 1ps
`default_nettype none

module rsp_packet_deframer #(
   parameter int LENGTH_BITS = rspd_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [2:0]       rsp_command,
   output logic [15:0]      rsp_data_length,
   output logic [7:0]       rsp_computed_sum
);

   localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;
   localparam logic [LENGTH_BITS-1:0] QS_COUNT  = LENGTH_BITS'(rspd_pkg::QS_LEN);

   rspd_pkg::phase_type   phase_ff, phase_in;
   logic [7:0]            sum_ff, sum_in;
   logic [3:0]            high_digit_ff, high_digit_in;
   logic                  high_bad_ff, high_bad_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic [2:0]            match_ff, match_in;
   logic                  check_enable_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   rspd_pkg::status_type  status_ff, status_in;
   rspd_pkg::command_type command_ff, command_in;
   logic [15:0]           length_ff, length_in;
   logic [7:0]            rsum_ff, rsum_in;
   logic                  load_result;

   logic                  xfer;
   logic [15:0]           length_sat;
   rspd_pkg::hex_type     digit;

   assign req_ready = !rsp_valid_ff || rsp_ready || (phase_ff != rspd_pkg::PHASE_LOW);
   assign xfer      = req_valid && req_ready;
   assign digit     = rspd_pkg::hex_decode(req_rx_byte);

   generate
      if (LENGTH_BITS > 16) begin : g_sat
         assign length_sat = (|count_ff[LENGTH_BITS-1:16]) ? 16'hffff : count_ff[15:0];
      end else begin : g_ext
         assign length_sat = 16'(count_ff);
      end
   endgenerate

   always_comb begin
      phase_in      = phase_ff;
      sum_in        = sum_ff;
      high_digit_in = high_digit_ff;
      high_bad_in   = high_bad_ff;
      count_in      = count_ff;
      match_in      = match_ff;
      load_result   = 1'b0;
      status_in     = rspd_pkg::STATUS_OK;
      command_in    = rspd_pkg::CMD_UNKNOWN;
      length_in     = length_sat;
      rsum_in       = sum_ff;
      if (xfer) begin
         case (phase_ff)
            rspd_pkg::PHASE_IDLE: begin
               if (req_rx_byte == rspd_pkg::CHAR_START) begin
                  phase_in      = rspd_pkg::PHASE_DATA;
                  sum_in        = '0;
                  high_digit_in = '0;
                  high_bad_in   = 1'b0;
                  count_in      = '0;
                  match_in      = rspd_pkg::MATCH_ALL;
               end
            end
            rspd_pkg::PHASE_DATA: begin
               if (req_rx_byte == rspd_pkg::CHAR_END) begin
                  phase_in = rspd_pkg::PHASE_HIGH;
               end else begin
                  if (count_ff == '0) begin
                     if (req_rx_byte != rspd_pkg::CHAR_READ) match_in[0] = 1'b0;
                     if (req_rx_byte != rspd_pkg::CHAR_WRITE) match_in[1] = 1'b0;
                  end
                  if (count_ff < QS_COUNT &&
                      req_rx_byte != rspd_pkg::qs_char(count_ff[3:0])) begin
                     match_in[2] = 1'b0;
                  end
                  sum_in = sum_ff + req_rx_byte;
                  if (count_ff != COUNT_MAX) count_in = count_ff + 1'b1;
               end
            end
            rspd_pkg::PHASE_HIGH: begin
               high_digit_in = digit.value;
               high_bad_in   = !digit.ok;
               phase_in      = rspd_pkg::PHASE_LOW;
            end
            default: begin
               load_result = 1'b1;
               if (!check_enable_ff) begin
                  status_in = rspd_pkg::STATUS_OK;
               end else if (high_bad_ff || !digit.ok) begin
                  status_in = rspd_pkg::STATUS_NON_HEX;
               end else if ({high_digit_ff, digit.value} != sum_ff) begin
                  status_in = rspd_pkg::STATUS_MISMATCH;
               end else begin
                  status_in = rspd_pkg::STATUS_OK;
               end
               if (count_ff == '0) command_in = rspd_pkg::CMD_EMPTY;
               else if (match_ff[0]) command_in = rspd_pkg::CMD_READ_REGS;
               else if (match_ff[1]) command_in = rspd_pkg::CMD_WRITE_REGS;
               else if (match_ff[2]) command_in = rspd_pkg::CMD_QUERY_SUP;
               else command_in = rspd_pkg::CMD_UNKNOWN;
               phase_in      = rspd_pkg::PHASE_IDLE;
               sum_in        = '0;
               high_digit_in = '0;
               high_bad_in   = 1'b0;
               count_in      = '0;
               match_in      = rspd_pkg::MATCH_ALL;
            end
         endcase
      end
      rsp_valid_in = load_result || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= rspd_pkg::PHASE_IDLE;
         sum_ff          <= '0;
         high_digit_ff   <= '0;
         high_bad_ff     <= 1'b0;
         count_ff        <= '0;
         match_ff        <= rspd_pkg::MATCH_ALL;
         check_enable_ff <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         sum_ff        <= sum_in;
         high_digit_ff <= high_digit_in;
         high_bad_ff   <= high_bad_in;
         count_ff      <= count_in;
         match_ff      <= match_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_enable) check_enable_ff <= csr_write_data;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load_result) begin
         status_ff  <= status_in;
         command_ff <= command_in;
         length_ff  <= length_in;
         rsum_ff    <= rsum_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_command      = command_ff;
   assign rsp_data_length  = length_ff;
   assign rsp_computed_sum = rsum_ff;

endmodule

`default_nettype wire
